[src/ps2_mouse_packet_decoder_assert.svh]
// ----------------------------------------------------------------------------
// ps2 mouse packet decoder assertion macros
// shared forms for the concurrent checks of the decoder modules
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_DECODER_ASSERT_SVH
`define PS2_MOUSE_PACKET_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PMD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/pmd_pkg.sv]
// ----------------------------------------------------------------------------
// pmd_pkg
// types and constants shared by the ps2 mouse packet decoder modules
// ----------------------------------------------------------------------------
`default_nettype none

package pmd_pkg;

    // event queue
    localparam int QUEUE_DEPTH = 64;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef logic [QPTR_W-1:0] t_qptr;

    // request codes
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE  = 2'd0,
        CFG_X_LIMIT = 2'd1,
        CFG_Y_LIMIT = 2'd2
    } t_cfg_idx;

    // packet framing
    localparam logic [7:0] SYNC_BIT    = 8'h08;
    localparam logic [2:0] BUTTON_MASK = 3'h7;

    // reset values
    localparam logic [6:0] X_LIMIT_RST = 7'd79;
    localparam logic [4:0] Y_LIMIT_RST = 5'd24;
    localparam logic [6:0] COLUMN_RST  = 7'd40;
    localparam logic [4:0] ROW_RST     = 5'd12;

    typedef struct packed {
        logic [2:0] buttons;
        logic [7:0] dx;
        logic [7:0] dy;
    } t_event;

    typedef struct packed {
        logic   push;
        t_event evt;
    } t_push_req;

    function automatic t_qptr qptr_inc(input t_qptr p);
        t_qptr r;
        if (p == t_qptr'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + t_qptr'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/pmd_cursor.sv]
// ----------------------------------------------------------------------------
// pmd_cursor
// configuration registers, 3-byte packet assembly and clamped cursor tracking
// ----------------------------------------------------------------------------
`default_nettype none

module pmd_cursor
    import pmd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_accept,
    input  wire logic                  i_req_type,
    input  wire logic [7:0]            i_data_byte,
    output logic      [6:0]            o_cursor_x,
    output logic      [4:0]            o_cursor_y,
    output logic      [2:0]            o_buttons,
    output t_push_req                  o_push
);

    typedef enum logic [2:0] {
        POS_FIRST  = 3'b001,
        POS_SECOND = 3'b010,
        POS_THIRD  = 3'b100
    } t_pos;

    logic       r_enable;
    logic [6:0] r_x_limit;
    logic [4:0] r_y_limit;
    t_pos       r_pos,    n_pos;
    logic [7:0] r_first,  n_first;
    logic [7:0] r_second, n_second;
    logic [6:0] r_column, n_column;
    logic [4:0] r_row,    n_row;
    logic [2:0] r_buttons, n_buttons;

    logic              take_byte;
    logic signed [8:0] col_sum;
    logic signed [8:0] row_sum;
    logic [2:0]        pkt_buttons;

    assign take_byte   = i_accept && (i_req_type == REQ_BYTE) && r_enable;
    assign pkt_buttons = r_first[2:0] & BUTTON_MASK;

    // column + dx and row - dy, both fit a 9-bit signed value
    assign col_sum = signed'({2'b00, r_column}) + signed'({r_second[7], r_second});
    assign row_sum = signed'({4'b0000, r_row}) - signed'({i_data_byte[7], i_data_byte});

    always_comb begin
        n_pos     = r_pos;
        n_first   = r_first;
        n_second  = r_second;
        n_column  = r_column;
        n_row     = r_row;
        n_buttons = r_buttons;
        o_push    = '0;
        if (take_byte) begin
            unique case (r_pos)
                POS_FIRST: begin
                    // no sync bit: drop the byte and keep hunting
                    if ((i_data_byte & SYNC_BIT) != 8'h00) begin
                        n_first = i_data_byte;
                        n_pos   = POS_SECOND;
                    end
                end
                POS_SECOND: begin
                    n_second = i_data_byte;
                    n_pos    = POS_THIRD;
                end
                POS_THIRD: begin
                    n_pos     = POS_FIRST;
                    n_buttons = pkt_buttons;
                    if (col_sum[8]) begin
                        n_column = '0;
                    end else if (col_sum[7:0] > {1'b0, r_x_limit}) begin
                        n_column = r_x_limit;
                    end else begin
                        n_column = col_sum[6:0];
                    end
                    if (row_sum[8]) begin
                        n_row = '0;
                    end else if (row_sum[7:0] > {3'b000, r_y_limit}) begin
                        n_row = r_y_limit;
                    end else begin
                        n_row = row_sum[4:0];
                    end
                    o_push.push = (r_second != 8'h00) || (i_data_byte != 8'h00)
                                  || (pkt_buttons != 3'b000);
                    o_push.evt.buttons = pkt_buttons;
                    o_push.evt.dx      = r_second;
                    o_push.evt.dy      = i_data_byte;
                end
                default: begin
                    n_pos = POS_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_x_limit <= X_LIMIT_RST;
            r_y_limit <= Y_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE:  r_enable  <= i_cfg_data[0];
                CFG_X_LIMIT: r_x_limit <= i_cfg_data[6:0];
                CFG_Y_LIMIT: r_y_limit <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_FIRST;
            r_first   <= '0;
            r_second  <= '0;
            r_column  <= COLUMN_RST;
            r_row     <= ROW_RST;
            r_buttons <= '0;
        end else begin
            r_pos     <= n_pos;
            r_first   <= n_first;
            r_second  <= n_second;
            r_column  <= n_column;
            r_row     <= n_row;
            r_buttons <= n_buttons;
        end
    end

    assign o_cursor_x = r_column;
    assign o_cursor_y = r_row;
    assign o_buttons  = r_buttons;

endmodule

`default_nettype wire

[src/pmd_event_fifo.sv]
// ----------------------------------------------------------------------------
// pmd_event_fifo
// ring of mouse events with one slot kept empty and a registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pmd_event_fifo
    import pmd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_accept,
    input  wire logic      i_req_type,
    input  t_push_req      i_push,
    output logic           o_pop_hit,
    output t_event         o_rd_data
);

    `include "ps2_mouse_packet_decoder_assert.svh"

    t_event r_mem [QUEUE_DEPTH];
    t_qptr  r_wr_ptr;
    t_qptr  r_rd_ptr;
    t_event r_rd_data;

    logic push_hit;
    t_qptr wr_next;

    assign wr_next   = qptr_inc(r_wr_ptr);
    // full ring drops the new event
    assign push_hit  = i_push.push && (wr_next != r_rd_ptr);
    assign o_pop_hit = i_accept && (i_req_type == REQ_POP) && (r_wr_ptr != r_rd_ptr);

    always_ff @(posedge i_clk) begin
        if (push_hit) begin
            r_mem[r_wr_ptr] <= i_push.evt;
        end
        if (o_pop_hit) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (push_hit) begin
                r_wr_ptr <= wr_next;
            end
            if (o_pop_hit) begin
                r_rd_ptr <= qptr_inc(r_rd_ptr);
            end
        end
    end

    assign o_rd_data = r_rd_data;

    `PMD_ASSERT_NOW(a_push_pop_excl, push_hit, !o_pop_hit, "push and pop from one item")
    `PMD_ASSERT_NEXT(a_pop_moves_rd, o_pop_hit, r_rd_ptr != $past(r_rd_ptr), "pop kept rd ptr")
    `PMD_ASSERT_NEXT(a_push_not_empty, push_hit, r_wr_ptr != r_rd_ptr, "ring empty after push")

endmodule

`default_nettype wire

[src/ps2_mouse_packet_decoder.sv]
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder
// ps2 mouse byte assembler with clamped cursor and a queue of mouse events
// ----------------------------------------------------------------------------
// One item is accepted per clock while o_in_stall is low; each item yields
// one result via stage 1 and the output register. Cursor, buttons and queue
// pointers update in the cycle the item is accepted, the queue memory read is
// registered in that same edge, and the result is then moved into an output
// register so a stalled result does not hold up the next item. Configuration
// writes take effect on the next clock and belong in idle periods.
`default_nettype none

module ps2_mouse_packet_decoder
    import pmd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_req_type,
    input  wire logic [7:0]            i_data_byte,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_event_valid,
    output logic        [2:0]          o_event_buttons,
    output logic signed [7:0]          o_event_dx,
    output logic signed [7:0]          o_event_dy,
    output logic        [6:0]          o_cursor_x,
    output logic        [4:0]          o_cursor_y,
    output logic        [2:0]          o_button_state
);

    `include "ps2_mouse_packet_decoder_assert.svh"

    logic      in_accept;
    logic      s1_move;
    logic      pop_hit;
    t_push_req push_req;
    t_event    rd_data;
    logic [6:0] cur_x;
    logic [4:0] cur_y;
    logic [2:0] cur_buttons;
    logic       ev_fields_zero;

    logic       r_s1_valid;
    logic       r_s1_ev_valid;
    logic       r_s2_valid;
    logic       r_out_ev_valid;
    t_event     r_out_event;
    logic [6:0] r_out_x;
    logic [4:0] r_out_y;
    logic [2:0] r_out_buttons;

    // stage 1 drains whenever the output register is free or being taken
    assign s1_move    = r_s1_valid && (!r_s2_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_accept  = i_in_valid && !o_in_stall;

    pmd_cursor u_cursor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_req_type  (i_req_type),
        .i_data_byte (i_data_byte),
        .o_cursor_x  (cur_x),
        .o_cursor_y  (cur_y),
        .o_buttons   (cur_buttons),
        .o_push      (push_req)
    );

    pmd_event_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_req_type (i_req_type),
        .i_push     (push_req),
        .o_pop_hit  (pop_hit),
        .o_rd_data  (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_s2_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    // state registers already reflect the item held in stage 1
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_ev_valid <= pop_hit;
        end
        if (s1_move) begin
            r_out_ev_valid <= r_s1_ev_valid;
            r_out_event    <= r_s1_ev_valid ? rd_data : '0;
            r_out_x        <= cur_x;
            r_out_y        <= cur_y;
            r_out_buttons  <= cur_buttons;
        end
    end

    assign o_out_valid     = r_s2_valid;
    assign o_event_valid   = r_out_ev_valid;
    assign o_event_buttons = r_out_event.buttons;
    assign o_event_dx      = signed'(r_out_event.dx);
    assign o_event_dy      = signed'(r_out_event.dy);
    assign o_cursor_x      = r_out_x;
    assign o_cursor_y      = r_out_y;
    assign o_button_state  = r_out_buttons;

    assign ev_fields_zero = (o_event_buttons == 3'b000) && (o_event_dx == 8'sd0)
                            && (o_event_dy == 8'sd0);

    `PMD_ASSERT_NOW(a_stall_full, o_in_stall, r_s1_valid && r_s2_valid, "stall with room free")
    `PMD_ASSERT_NEXT(a_s1_drains, r_s1_valid && !r_s2_valid, r_s2_valid, "stage 1 not drained")
    `PMD_ASSERT_NOW(a_no_event_zero, o_out_valid && !o_event_valid, ev_fields_zero, "event set")

endmodule

`default_nettype wire

[sim/tb_ps2_mouse_packet_decoder.sv]
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_decoder
// self-checking bench: mouse bytes and pop requests go in through a random-gap
// driver, every result is checked against a cycle-free decoder model
// ----------------------------------------------------------------------------
module tb_ps2_mouse_packet_decoder;
    import pmd_pkg::*;

    typedef struct {
        logic       req;
        logic [7:0] b;
    } t_request;

    typedef struct {
        logic       ev;
        logic [2:0] btn;
        logic [7:0] dx;
        logic [7:0] dy;
        logic [6:0] cx;
        logic [4:0] cy;
        logic [2:0] bs;
    } t_report;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  req_type  = REQ_BYTE;
    logic [7:0]            data_byte = 8'h00;
    logic                  out_stall = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic                  ev_valid;
    logic [2:0]            ev_buttons;
    logic signed [7:0]     ev_dx;
    logic signed [7:0]     ev_dy;
    logic [6:0]            cur_x;
    logic [4:0]            cur_y;
    logic [2:0]            btn_state;

    ps2_mouse_packet_decoder dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_req_type      (req_type),
        .i_data_byte     (data_byte),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_event_valid   (ev_valid),
        .o_event_buttons (ev_buttons),
        .o_event_dx      (ev_dx),
        .o_event_dy      (ev_dy),
        .o_cursor_x      (cur_x),
        .o_cursor_y      (cur_y),
        .o_button_state  (btn_state)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // decoder model state
    logic       en_m;
    logic [6:0] xlim_m;
    logic [4:0] ylim_m;
    logic [1:0] pos_m;
    logic [7:0] first_m;
    logic [7:0] second_m;
    logic [6:0] col_m;
    logic [4:0] row_m;
    logic [2:0] btn_m;
    t_event     store_m [QUEUE_DEPTH];
    t_qptr      wp_m;
    t_qptr      rp_m;

    t_request request_q [$];
    t_report  report_q [$];
    logic     gaps_on = 1'b1;
    int       errors = 0;
    int       accepted = 0;
    int       packets_done = 0;
    int       popped = 0;
    int       empty_pops = 0;
    int       dropped = 0;
    int       cfg_writes = 0;

    function automatic int clamp_int(int v, int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_qptr ring_next(t_qptr p);
        return t_qptr'((int'(p) + 1) % QUEUE_DEPTH);
    endfunction

    function automatic void decode_request(logic req, logic [7:0] b);
        t_report r;
        int      nx;
        int      ny;
        r = '{default: '0};
        if (req == REQ_BYTE) begin
            if (en_m) begin
                if (pos_m == 2'd0) begin
                    // no sync bit on the head byte: drop it and stay aligned
                    if ((b & SYNC_BIT) != 8'h00) begin
                        first_m = b;
                        pos_m   = 2'd1;
                    end
                end else if (pos_m == 2'd1) begin
                    second_m = b;
                    pos_m    = 2'd2;
                end else begin
                    pos_m = 2'd0;
                    packets_done++;
                    btn_m = first_m[2:0] & BUTTON_MASK;
                    nx    = int'(col_m) + int'($signed(second_m));
                    ny    = int'(row_m) - int'($signed(b));
                    col_m = 7'(clamp_int(nx, int'(xlim_m)));
                    row_m = 5'(clamp_int(ny, int'(ylim_m)));
                    if (second_m != 8'h00 || b != 8'h00 || btn_m != 3'd0) begin
                        if (ring_next(wp_m) != rp_m) begin
                            store_m[wp_m] = '{btn_m, second_m, b};
                            wp_m = ring_next(wp_m);
                        end else begin
                            dropped++;
                        end
                    end
                end
            end
        end else if (wp_m != rp_m) begin
            r.ev  = 1'b1;
            r.btn = store_m[rp_m].buttons;
            r.dx  = store_m[rp_m].dx;
            r.dy  = store_m[rp_m].dy;
            rp_m  = ring_next(rp_m);
            popped++;
        end else begin
            empty_pops++;
        end
        r.cx = col_m;
        r.cy = row_m;
        r.bs = btn_m;
        report_q.push_back(r);
    endfunction

    function automatic void check_field(string name, int got, int want);
        if (got != want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                decode_request(req_type, data_byte);
                accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (request_q.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 10)) begin
                    in_valid  <= 1'b1;
                    req_type  <= request_q[0].req;
                    data_byte <= request_q[0].b;
                    void'(request_q.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_report w;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (report_q.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, actual cursor %0d,%0d",
                             $time, cur_x, cur_y);
                    errors++;
                end else begin
                    w = report_q.pop_front();
                    check_field("event_valid", int'(ev_valid), int'(w.ev));
                    check_field("event_buttons", int'(ev_buttons), int'(w.btn));
                    check_field("event_dx", int'(ev_dx), int'($signed(w.dx)));
                    check_field("event_dy", int'(ev_dy), int'($signed(w.dy)));
                    check_field("cursor_x", int'(cur_x), int'(w.cx));
                    check_field("cursor_y", int'(cur_y), int'(w.cy));
                    check_field("button_state", int'(btn_state), int'(w.bs));
                end
            end
            out_stall <= gaps_on && ($urandom_range(0, 99) < 10);
        end
    end

    task automatic add_byte(logic [7:0] b);
        request_q.push_back('{REQ_BYTE, b});
    endtask

    task automatic add_pop();
        request_q.push_back('{REQ_POP, 8'($urandom_range(0, 255))});
    endtask

    task automatic add_packet(logic [7:0] head, logic [7:0] dx, logic [7:0] dy);
        add_byte(head | SYNC_BIT);
        add_byte(dx);
        add_byte(dy);
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (request_q.size() != 0 || in_valid || report_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLE:  en_m   = val[0];
            CFG_X_LIMIT: xlim_m = val[6:0];
            CFG_Y_LIMIT: ylim_m = val[4:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // random mix, mostly well-formed packets
    task automatic add_mix(int count);
        int         n;
        int         r;
        logic [7:0] head;
        n = 0;
        while (n < count) begin
            r    = $urandom_range(0, 99);
            head = 8'($urandom_range(0, 255));
            if (r < 10) begin
                // motionless packet, often with no buttons
                if ($urandom_range(0, 1) == 1) head[2:0] = 3'd0;
                add_packet(head, 8'h00, 8'h00);
                n += 3;
            end else if (r < 50) begin
                add_packet(head, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                n += 3;
            end else if (r < 80) begin
                add_pop();
                n += 1;
            end else if (r < 90) begin
                add_byte(8'($urandom_range(0, 255)));
                n += 1;
            end else begin
                // truncated packet
                add_byte(head | SYNC_BIT);
                add_byte(8'($urandom_range(0, 255)));
                n += 2;
            end
        end
    endtask

    initial begin
        en_m     = 1'b0;
        xlim_m   = X_LIMIT_RST;
        ylim_m   = Y_LIMIT_RST;
        pos_m    = 2'd0;
        first_m  = 8'h00;
        second_m = 8'h00;
        col_m    = COLUMN_RST;
        row_m    = ROW_RST;
        btn_m    = 3'd0;
        wp_m     = '0;
        rp_m     = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // disabled after reset, pop on an empty queue
        add_byte(8'h08);
        add_pop();
        wait_idle();
        write_reg(CFG_ENABLE, 7'd1);

        add_byte(8'h00);
        add_packet(8'h08, 8'h00, 8'h00);
        add_packet(8'hFF, 8'h7F, 8'h80);
        add_packet(8'h0C, 8'h80, 8'h7F);
        add_packet(8'h09, 8'h01, 8'hFF);
        repeat (4) add_pop();
        // half a packet, then disable: the partial packet must survive
        add_byte(8'h0A);
        add_byte(8'h05);
        wait_idle();
        write_reg(CFG_ENABLE, 7'd0);
        add_byte(8'h33);
        add_pop();
        wait_idle();
        write_reg(CFG_ENABLE, 7'd1);
        add_byte(8'hFE);
        add_pop();
        add_packet(8'h08, 8'h7F, 8'h00);
        add_packet(8'h08, 8'h7F, 8'h00);
        wait_idle();
        // cursor stays beyond the lowered limits until the next packet
        write_reg(CFG_X_LIMIT, 7'd3);
        write_reg(CFG_Y_LIMIT, 7'd2);
        add_pop();
        add_packet(8'h08, 8'h00, 8'h00);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            gaps_on = (ph != 3);
            case (ph)
                0: begin
                    write_reg(CFG_X_LIMIT, 7'd0);
                    write_reg(CFG_Y_LIMIT, 7'd0);
                    write_reg(CFG_ENABLE, 7'd1);
                end
                1: begin
                    write_reg(CFG_X_LIMIT, 7'd127);
                    write_reg(CFG_Y_LIMIT, 7'd31);
                    write_reg(CFG_ENABLE, 7'd1);
                end
                4: write_reg(CFG_ENABLE, 7'd1);
                default: begin
                    write_reg(CFG_X_LIMIT, 7'($urandom_range(0, 127)));
                    write_reg(CFG_Y_LIMIT, 7'($urandom_range(0, 31)));
                    write_reg(CFG_ENABLE, 7'($urandom_range(0, 5) != 0));
                end
            endcase
            if (ph == 4) begin
                // overfill the event ring, then drain it
                repeat (QUEUE_DEPTH + 4)
                    add_packet(8'($urandom_range(0, 255)) | 8'h01,
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                repeat (QUEUE_DEPTH + 2) add_pop();
            end else begin
                add_mix(150);
            end
            wait_idle();
        end

        repeat (8) @(negedge clk);
        $display("%0d requests, %0d packets, %0d configuration writes",
                 accepted, packets_done, cfg_writes);
        $display("%0d events popped, %0d empty pops, %0d events lost to a full queue",
                 popped, empty_pops, dropped);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[ps2_mouse_packet_decoder.f]
+incdir+src
src/pmd_pkg.sv
src/pmd_cursor.sv
src/pmd_event_fifo.sv
src/ps2_mouse_packet_decoder.sv
sim/tb_ps2_mouse_packet_decoder.sv
